/* rtl/ctfp_pkg.sv */
// shared types and constants for the coap tcp frame parser
`timescale 1ns / 1ps
`default_nettype none
package ctfp_pkg;
   localparam int unsigned MAX_TOKEN = 8;

   localparam logic [2:0] KIND_CODE    = 3'd0;
   localparam logic [2:0] KIND_TOKEN   = 3'd1;
   localparam logic [2:0] KIND_OPTBYTE = 3'd2;
   localparam logic [2:0] KIND_OPTDONE = 3'd3;
   localparam logic [2:0] KIND_PAYLOAD = 3'd4;
   localparam logic [2:0] KIND_STATUS  = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_CRIT  = 2'd2;
   localparam logic [1:0] ST_PROXY = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] opt_id;
      logic [16:0] opt_len;
      logic [31:0] uint_value;
      logic [27:0] blk_index;
      logic        block_more;
      logic [2:0]  block_size_exp;
      logic [32:0] declared_length;
      logic [3:0]  token_length;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // one queue entry: up to three results caused by one byte
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
      rsp_type    r2;
   } group_type;

   function automatic logic is_known(input logic [15:0] num);
      case (num)
         16'd1, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd11, 16'd12, 16'd14,
         16'd15, 16'd17, 16'd20, 16'd23, 16'd27, 16'd28, 16'd60: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction
endpackage
`default_nettype wire

/* rtl/ctfp_stream_if.sv */
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none
interface ctfp_req_if;
   logic              valid;
   logic              ready;
   ctfp_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ctfp_rsp_if;
   logic              valid;
   logic              ready;
   ctfp_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/ctfp_front.sv */
// parser front: decodes one byte per beat into a group of up to three results
`timescale 1ns / 1ps
`default_nettype none
module ctfp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire ctfp_pkg::req_type   req,
   output ctfp_pkg::group_type      grp
);
   localparam logic [2:0] PH_HDR = 3'd0, PH_EXT = 3'd1, PH_CODE = 3'd2, PH_TOKEN = 3'd3,
      PH_OPTHDR = 3'd4, PH_OPTEXT = 3'd5, PH_VALUE = 3'd6, PH_PAYLOAD = 3'd7;
   localparam logic [33:0] SEEN_MAX = '1;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  ext_left_ff, ext_left_in;
   logic [2:0]  ext_count_ff, ext_count_in;
   logic [1:0]  len_left_ff, len_left_in;
   logic [32:0] body_ff, body_in;
   logic [3:0]  tkl_ff, tkl_in;
   logic [3:0]  tok_left_ff, tok_left_in;
   logic [15:0] onum_ff, onum_in;
   logic [16:0] delta_ff, delta_in;
   logic [16:0] olen_ff, olen_in;
   logic [16:0] vleft_ff, vleft_in;
   logic [31:0] iacc_ff, iacc_in;
   logic [33:0] seen_ff, seen_in;
   logic [1:0]  err_ff, err_in;

   // register update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR; ext_left_ff <= '0; ext_count_ff <= '0; len_left_ff <= '0;
         body_ff <= '0; tkl_ff <= '0; tok_left_ff <= '0; onum_ff <= '0; delta_ff <= '0;
         olen_ff <= '0; vleft_ff <= '0; iacc_ff <= '0; seen_ff <= '0; err_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in; ext_left_ff <= ext_left_in; ext_count_ff <= ext_count_in;
         len_left_ff <= len_left_in; body_ff <= body_in; tkl_ff <= tkl_in;
         tok_left_ff <= tok_left_in; onum_ff <= onum_in; delta_ff <= delta_in;
         olen_ff <= olen_in; vleft_ff <= vleft_in; iacc_ff <= iacc_in;
         seen_ff <= seen_in; err_ff <= err_in;
      end
   end

   function automatic ctfp_pkg::rsp_type mk_done(input logic [15:0] num,
         input logic [16:0] len, input logic [31:0] v);
      ctfp_pkg::rsp_type r;
      r = '0;
      r.kind = ctfp_pkg::KIND_OPTDONE;
      r.opt_id = num;
      r.opt_len = len;
      r.uint_value = v;
      if (num == 16'd23 || num == 16'd27) begin
         r.blk_index = v[31:4];
         r.block_more = v[3];
         r.block_size_exp = v[2:0];
      end
      return r;
   endfunction

   // next state and result group
   always_comb begin
      logic [7:0]  b;
      logic [3:0]  dn, ln;
      logic        fin;
      logic [17:0] nsum;
      logic [15:0] num;
      logic [34:0] need;
      ctfp_pkg::rsp_type r [3];
      logic [1:0]  n;
      b = req.in_byte;
      dn = b[7:4]; ln = b[3:0];
      fin = 1'b0; nsum = '0; num = '0; need = '0;
      r[0] = '0; r[1] = '0; r[2] = '0; n = 2'd0;
      phase_in = phase_ff; ext_left_in = ext_left_ff; ext_count_in = ext_count_ff;
      len_left_in = len_left_ff; body_in = body_ff; tkl_in = tkl_ff;
      tok_left_in = tok_left_ff; onum_in = onum_ff; delta_in = delta_ff;
      olen_in = olen_ff; vleft_in = vleft_ff; iacc_in = iacc_ff; err_in = err_ff;
      seen_in = (seen_ff != SEEN_MAX) ? seen_ff + 34'd1 : seen_ff;

      if (err_ff == ctfp_pkg::ST_OK) begin
         unique case (phase_ff)
            PH_HDR: begin
               tkl_in = (ln < 4'(ctfp_pkg::MAX_TOKEN)) ? ln : 4'(ctfp_pkg::MAX_TOKEN);
               if (dn < 4'd13) begin
                  body_in = 33'(dn); ext_count_in = '0; phase_in = PH_CODE;
               end else begin
                  body_in = '0;
                  ext_count_in = (dn == 4'd13) ? 3'd1 : ((dn == 4'd14) ? 3'd2 : 3'd4);
                  ext_left_in = ext_count_in; phase_in = PH_EXT;
               end
            end
            PH_EXT: begin
               body_in = {1'b0, body_ff[23:0], b};
               if (ext_left_ff != 3'd0) ext_left_in = ext_left_ff - 3'd1;
               if (ext_left_in == 3'd0) begin
                  body_in = body_in + ((ext_count_ff == 3'd1) ? 33'd13 :
                     ((ext_count_ff == 3'd2) ? 33'd269 : 33'd65805));
                  phase_in = PH_CODE;
               end
            end
            PH_CODE: begin
               r[0].kind = ctfp_pkg::KIND_CODE; r[0].data_byte = b;
               r[0].declared_length = body_ff; r[0].token_length = tkl_ff; n = 2'd1;
               tok_left_in = tkl_ff;
               phase_in = (tkl_ff != 4'd0) ? PH_TOKEN : PH_OPTHDR;
            end
            PH_TOKEN: begin
               r[0].kind = ctfp_pkg::KIND_TOKEN; r[0].data_byte = b; n = 2'd1;
               if (tok_left_ff != 4'd0) tok_left_in = tok_left_ff - 4'd1;
               if (tok_left_in == 4'd0) phase_in = PH_OPTHDR;
            end
            PH_OPTHDR: begin
               if (dn == 4'd15) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  delta_in = 17'(dn); olen_in = 17'(ln);
                  ext_left_in = '0; len_left_in = '0;
                  if (dn == 4'd13) ext_left_in = 3'd1;
                  else if (dn == 4'd14) begin ext_left_in = 3'd2; delta_in = 17'd269; end
                  if (ln == 4'd13) len_left_in = 2'd1;
                  else if (ln == 4'd14) begin len_left_in = 2'd2; olen_in = 17'd269; end
                  if (ext_left_in == 3'd0 && len_left_in == 2'd0) fin = 1'b1;
                  else phase_in = PH_OPTEXT;
               end
            end
            PH_OPTEXT: begin
               if (ext_left_ff != 3'd0) begin
                  delta_in = delta_ff + ((ext_left_ff == 3'd2) ? {1'b0, b, 8'd0} : 17'(b));
                  ext_left_in = ext_left_ff - 3'd1;
               end else if (len_left_ff != 2'd0) begin
                  olen_in = olen_ff + ((len_left_ff == 2'd2) ? {1'b0, b, 8'd0} : 17'(b));
                  len_left_in = len_left_ff - 2'd1;
               end
               if (ext_left_in == 3'd0 && len_left_in == 2'd0) fin = 1'b1;
            end
            PH_VALUE: begin
               r[0].kind = ctfp_pkg::KIND_OPTBYTE; r[0].data_byte = b;
               r[0].opt_id = onum_ff; r[0].opt_len = olen_ff; n = 2'd1;
               iacc_in = {iacc_ff[23:0], b};
               if (vleft_ff != 17'd0) vleft_in = vleft_ff - 17'd1;
               if (vleft_in == 17'd0) begin
                  r[1] = mk_done(onum_ff, olen_ff, iacc_in); n = 2'd2;
                  phase_in = PH_OPTHDR;
               end
            end
            PH_PAYLOAD: begin
               r[0].kind = ctfp_pkg::KIND_PAYLOAD; r[0].data_byte = b; n = 2'd1;
            end
            default: ;
         endcase

         // option header complete: number update and checks
         if (fin) begin
            nsum = 18'(onum_ff) + 18'(delta_in);
            num = (nsum[17:16] != 2'd0) ? 16'hFFFF : nsum[15:0];
            onum_in = num;
            if (num == 16'd35 || num == 16'd39) err_in = ctfp_pkg::ST_PROXY;
            else if (!ctfp_pkg::is_known(num) && num[0]) err_in = ctfp_pkg::ST_CRIT;
            else begin
               vleft_in = olen_in; iacc_in = '0;
               if (olen_in == 17'd0) begin
                  phase_in = PH_OPTHDR;
                  r[0] = mk_done(num, olen_in, 32'd0); n = 2'd1;
               end else phase_in = PH_VALUE;
            end
         end
      end

      // frame end closes with a status result
      if (req.frame_end) begin
         need = 35'(ext_count_in) + 35'(tkl_in) + 35'd2 + 35'(body_in);
         r[n] = '0;
         r[n].kind = ctfp_pkg::KIND_STATUS;
         r[n].status = (35'(seen_in) < need) ? ctfp_pkg::ST_SHORT : err_in;
         n = n + 2'd1;
         phase_in = PH_HDR; ext_left_in = '0; ext_count_in = '0; len_left_in = '0;
         body_in = '0; tkl_in = '0; tok_left_in = '0; onum_in = '0; delta_in = '0;
         olen_in = '0; vleft_in = '0; iacc_in = '0; seen_in = '0; err_in = '0;
      end

      if (n != 2'd0) r[n - 2'd1].last = 1'b1;
      grp.count = n; grp.r0 = r[0]; grp.r1 = r[1]; grp.r2 = r[2];
   end
endmodule
`default_nettype wire

/* rtl/ctfp_back.sv */
// two-entry group queue, serialized one result beat per cycle while rsp.ready
`timescale 1ns / 1ps
`default_nettype none
module ctfp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ctfp_pkg::group_type  grp,
   output logic                      room,
   ctfp_rsp_if.source                rsp
);
   ctfp_pkg::group_type q_ff [2];
   ctfp_pkg::group_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       pop;

   // head group walks its results in order
   always_comb begin
      rsp.valid = (cnt_ff != 2'd0);
      case (idx_ff)
         2'd0:    rsp.payload = q_ff[0].r0;
         2'd1:    rsp.payload = q_ff[0].r1;
         default: rsp.payload = q_ff[0].r2;
      endcase
      pop = rsp.valid && rsp.ready && (idx_ff + 2'd1 == q_ff[0].count);
      room = (cnt_ff != 2'd2) || pop;
      idx_in = (rsp.valid && rsp.ready) ? (pop ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      q_in[0] = q_ff[0]; q_in[1] = q_ff[1]; cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1]; cnt_in = cnt_ff - 2'd1;
      end
      if (push && grp.count != 2'd0) begin
         q_in[cnt_in[0]] = grp; cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= '0; idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in; idx_ff <= idx_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/coap_tcp_frame_parser.sv */
// CoAP over TCP frame parser top level
//
// req channel: one frame byte per beat with a frame-end flag.
// rsp channel: result beats (code, token, option bytes, option done,
// payload, frame status), up to three per input byte, last set on the
// final result of each byte. Every frame ends with a status beat.
// The front decodes a byte in the cycle it is accepted; its results are
// registered in a two-entry group queue and leave on rsp one per cycle
// while rsp is ready. Throughput is one byte per cycle while each byte
// yields at most one result and rsp is ready; a byte with two or three
// results holds the output longer; req.ready drops once the queue is full.
// Reset (synchronous) returns the parser to the first header byte and
// empties the queue. A stalled rsp fills the queue and then stalls req;
// nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module coap_tcp_frame_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   ctfp_req_if.sink   req,
   ctfp_rsp_if.source rsp
);
   ctfp_pkg::group_type grp;
   logic room;
   logic take;

   assign req.ready = room;
   assign take = req.valid && room;

   ctfp_front u_front (.clock(clock), .reset(reset), .take(take), .req(req.payload),
      .grp(grp));

   ctfp_back u_back (.clock(clock), .reset(reset), .push(take), .grp(grp), .room(room),
      .rsp(rsp));
endmodule
`default_nettype wire
